>>> design/wmma_pkg.sv
// ----------------------------------------------------------------------------
// wmma_pkg: shared constants for the sliding window min/max/average block
// Field width of the sample and result ports, and default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package wmma_pkg;

    localparam int FIELD_BITS      = 12;
    localparam int WINDOW_DEF      = 20;
    localparam int SAMPLE_BITS_DEF = 12;

endpackage : wmma_pkg

`default_nettype wire

>>> design/wmma_ram.sv
// ----------------------------------------------------------------------------
// wmma_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wmma_ram #(
    parameter int WIDTH = wmma_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH = wmma_pkg::WINDOW_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : wmma_ram

`default_nettype wire

>>> design/wmma_div.sv
// ----------------------------------------------------------------------------
// wmma_div: divider by a constant
// Reciprocal multiply and shift, quotient registered in the cycle after start.
// ----------------------------------------------------------------------------
`default_nettype none

module wmma_div #(
    parameter int NUM_BITS = wmma_pkg::SAMPLE_BITS_DEF + $clog2(wmma_pkg::WINDOW_DEF),
    parameter int DIVISOR  = wmma_pkg::WINDOW_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    output logic                     o_done,
    output logic      [NUM_BITS-1:0] o_quo
);

    // exact for every dividend below 2**NUM_BITS
    localparam int SHIFT     = NUM_BITS + $clog2(DIVISOR);
    localparam int MULT_BITS = NUM_BITS + 1;
    localparam int PROD_BITS = NUM_BITS + MULT_BITS;
    localparam logic [MULT_BITS-1:0] RECIP =
        MULT_BITS'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic                 r_done;
    logic [NUM_BITS-1:0]  r_quo;
    logic [PROD_BITS-1:0] w_prod;

    assign w_prod = PROD_BITS'(i_num) * PROD_BITS'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= NUM_BITS'(w_prod >> SHIFT);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule : wmma_div

`default_nettype wire

>>> design/sliding_window_min_max_avg.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_avg: windowed mean, minimum and maximum of samples
//
// Input channel i_valid/o_ready carries one sample word; output channel
// o_valid/i_ready carries one result word (average, minimum, maximum) per
// sample. Each sample overwrites the oldest of the last WINDOW samples in a
// RAM, then the whole window is read back one entry per cycle to form sum,
// minimum and maximum; the sum is divided by WINDOW with a reciprocal
// multiply. After a sample is accepted the block runs the RAM scan, a drain
// state, the divider start and wait states and the hold state, which loads
// the result into the output register once it is free. One sample is in
// work at a time; o_ready rises in the same cycle as the result is loaded
// into the output register.
// Reset clears the window (per-entry valid bits make unwritten slots read
// as zero), the slot pointer and the output valid flag; no clearing pass.
// A stalled receiver holds the result word; one more sample may be taken,
// its finished result then waits internally and input stays blocked until
// the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_min_max_avg #(
    parameter int WINDOW      = wmma_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = wmma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [wmma_pkg::FIELD_BITS-1:0] i_sample,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [wmma_pkg::FIELD_BITS-1:0] o_average,
    output logic      [wmma_pkg::FIELD_BITS-1:0] o_minimum,
    output logic      [wmma_pkg::FIELD_BITS-1:0] o_maximum
);

    localparam int SLOT_BITS = $clog2(WINDOW);
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int OUT_BITS  = wmma_pkg::FIELD_BITS;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DSTART,
        ST_DWAIT,
        ST_HOLD
    } t_state;

    t_state                 r_state;
    logic [SLOT_BITS-1:0]   r_slot;
    logic [SLOT_BITS-1:0]   r_addr;
    logic [WINDOW-1:0]      r_valid;
    logic                   r_rd_pend;
    logic                   r_rd_vld;
    logic [SUM_BITS-1:0]    r_sum;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;
    logic                   r_o_valid;
    logic [OUT_BITS-1:0]    r_avg;
    logic [OUT_BITS-1:0]    r_omin;
    logic [OUT_BITS-1:0]    r_omax;

    logic                   w_accept;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [SAMPLE_BITS-1:0] w_rdata;
    logic [SAMPLE_BITS-1:0] w_entry;
    logic                   w_div_done;
    logic [SUM_BITS-1:0]    w_quo;

    logic [SUM_BITS-1:0]    n_sum;
    logic [SAMPLE_BITS-1:0] n_min;
    logic [SAMPLE_BITS-1:0] n_max;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_sample = SAMPLE_BITS'(i_sample);

    wmma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_slot),
        .i_wdata (w_sample),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    wmma_div #(
        .NUM_BITS (SUM_BITS),
        .DIVISOR  (WINDOW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DSTART),
        .i_num   (r_sum),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // slots never written since reset read as zero
    always_comb begin
        w_entry = r_rd_vld ? w_rdata : '0;
        n_sum   = r_sum + SUM_BITS'(w_entry);
        n_min   = (w_entry < r_min) ? w_entry : r_min;
        n_max   = (w_entry > r_max) ? w_entry : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_slot    <= '0;
            r_addr    <= '0;
            r_valid   <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_pend <= (r_state == ST_SCAN);
            r_rd_vld  <= r_valid[r_addr];
            if ((r_state == ST_HOLD) && (!r_o_valid || i_ready)) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_rd_pend) begin
                r_sum <= n_sum;
                r_min <= n_min;
                r_max <= n_max;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_valid[r_slot] <= 1'b1;
                        r_slot  <= (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_BITS'(1);
                        r_addr  <= '0;
                        r_sum   <= '0;
                        r_min   <= '1;
                        r_max   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_addr == LAST_SLOT) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_addr <= r_addr + SLOT_BITS'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_DSTART;
                end
                ST_DSTART: begin
                    r_state <= ST_DWAIT;
                end
                ST_DWAIT: begin
                    if (w_div_done) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (!r_o_valid || i_ready) begin
                        r_avg     <= OUT_BITS'(w_quo);
                        r_omin    <= OUT_BITS'(r_min);
                        r_omax    <= OUT_BITS'(r_max);
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid   = r_o_valid;
    assign o_average = r_avg;
    assign o_minimum = r_omin;
    assign o_maximum = r_omax;

    a_min_le_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> (r_min <= r_max))
        else $error("window minimum above maximum");

    a_avg_le_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> (w_quo <= SUM_BITS'(r_max)))
        else $error("window average above maximum");

    a_slot_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("slot pointer out of window");

    a_div_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DWAIT))
        else $error("divider done outside wait state");

endmodule : sliding_window_min_max_avg

`default_nettype wire
